@@ rtl/ncle_pkg.sv @@
// Shared types, codes and the noise divisor table for the noise channel.
package ncle_pkg;

    localparam int unsigned TimerWidth = 23;
    localparam int unsigned LfsrWidth  = 15;

    localparam logic [LfsrWidth-1:0] LfsrSeed = 15'h7FFF;

    typedef logic [2:0] op_code_t;

    localparam op_code_t OP_WRITE   = 3'd0;
    localparam op_code_t OP_READ    = 3'd1;
    localparam op_code_t OP_ADVANCE = 3'd2;
    localparam op_code_t OP_LENGTH  = 3'd3;
    localparam op_code_t OP_ENV     = 3'd4;

    typedef logic [1:0] reg_sel_t;

    localparam reg_sel_t REG_LENGTH  = 2'd0;
    localparam reg_sel_t REG_VOLUME  = 2'd1;
    localparam reg_sel_t REG_POLY    = 2'd2;
    localparam reg_sel_t REG_CONTROL = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_DONE
    } state_t;

    // Base timer period for each divisor code.
    function automatic logic [6:0] base_period(input logic [2:0] sel);
        logic [6:0] p;
        case (sel)
            3'd0:    p = 7'd8;
            3'd1:    p = 7'd16;
            3'd2:    p = 7'd32;
            3'd3:    p = 7'd48;
            3'd4:    p = 7'd64;
            3'd5:    p = 7'd80;
            3'd6:    p = 7'd96;
            3'd7:    p = 7'd112;
            default: p = 7'd8;
        endcase
        return p;
    endfunction

    // One LFSR step; in short mode bit 6 also takes the feedback bit.
    function automatic logic [LfsrWidth-1:0] lfsr_step(input logic [LfsrWidth-1:0] l,
                                                       input logic short_m);
        logic                 fb;
        logic [LfsrWidth-1:0] n;
        fb = l[0] ^ l[1];
        n  = {fb, l[LfsrWidth-1:1]};
        if (short_m)
        begin
            n[6] = fb;
        end
        return n;
    endfunction

endpackage

@@ rtl/ncle_in_if.sv @@
// Request channel: one operation item with valid/ready handshake.
interface ncle_in_if
    import ncle_pkg::*;
();
    logic       valid;
    logic       ready;
    op_code_t   op;
    reg_sel_t   reg_index;
    logic [7:0] write_data;
    logic [7:0] cycles;

    modport source (output valid, output op, output reg_index, output write_data,
                    output cycles, input ready);
    modport sink   (input valid, input op, input reg_index, input write_data,
                    input cycles, output ready);
endinterface

@@ rtl/ncle_out_if.sv @@
// Response channel: read data, sample and channel status with valid/ready handshake.
interface ncle_out_if
    import ncle_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;

    modport source (output valid, output read_data, output sample, output channel_on,
                    input ready);
    modport sink   (input valid, input read_data, input sample, input channel_on,
                    output ready);
endinterface

@@ rtl/noise_channel_lfsr_envelope_core.sv @@
// Noise channel: LFSR, reload timer, length counter and envelope under a small sequencer.
// Each item passes EXEC and then DONE; a trigger write or an advance that expires
// the timer also passes SHIFT between them, where the reload value is built by
// repeated doubling through the one shared 23-bit adder.
// A new item is taken while a result waits in the output register.
// Reset: asynchronous, clears all channel state and sets the LFSR to all ones.
module noise_channel_lfsr_envelope_core
    import ncle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ncle_in_if.sink     req,
    ncle_out_if.source  rsp
);

    state_t state_reg, state_next;

    // Latched item
    op_code_t   op_reg;
    reg_sel_t   idx_reg;
    logic [7:0] data_reg;
    logic [7:0] cyc_reg;

    // Channel state
    logic [7:0]            vol_copy_reg, vol_copy_next;
    logic [7:0]            ctl_copy_reg, ctl_copy_next;
    logic                  en_reg, en_next;
    logic                  dac_reg, dac_next;
    logic                  len_on_reg, len_on_next;
    logic [TimerWidth-1:0] timer_reg, timer_next;
    logic [6:0]            len_cnt_reg, len_cnt_next;
    logic [3:0]            env_cd_reg, env_cd_next;
    logic [2:0]            env_per_reg, env_per_next;
    logic                  env_up_reg, env_up_next;
    logic [3:0]            env_start_reg, env_start_next;
    logic [3:0]            vol_reg, vol_next;
    logic [3:0]            shift_reg, shift_next;
    logic                  short_reg, short_next;
    logic [2:0]            div_reg, div_next;
    logic [LfsrWidth-1:0]  lfsr_reg, lfsr_next;

    // Shared adder and its reload accumulator
    logic [TimerWidth-1:0] acc_reg, acc_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [TimerWidth-1:0] alu_a, alu_b, alu_sum;
    logic                  alu_cin;

    logic [7:0] rd_reg, rd_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_rd_reg, out_rd_next;
    logic [3:0] out_smp_reg, out_smp_next;
    logic       out_on_reg, out_on_next;

    logic       accept;
    logic [3:0] env_cd_dec;
    logic [6:0] len_dec;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rd_reg;
    assign rsp.sample     = out_smp_reg;
    assign rsp.channel_on = out_on_reg;

    // Timer subtract in EXEC, doubling of the reload value in SHIFT
    always_comb
    begin
        if (state_reg == S_SHIFT)
        begin
            alu_a   = acc_reg;
            alu_b   = acc_reg;
            alu_cin = 1'b0;
        end
        else
        begin
            alu_a   = timer_reg;
            alu_b   = ~{{(TimerWidth-8){1'b0}}, cyc_reg};
            alu_cin = 1'b1;
        end
        alu_sum = alu_a + alu_b + {{(TimerWidth-1){1'b0}}, alu_cin};
    end

    assign env_cd_dec = (env_cd_reg != 4'd0) ? env_cd_reg - 4'd1 : env_cd_reg;
    assign len_dec    = (len_cnt_reg != 7'd0) ? len_cnt_reg - 7'd1 : len_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        vol_copy_next  = vol_copy_reg;
        ctl_copy_next  = ctl_copy_reg;
        en_next        = en_reg;
        dac_next       = dac_reg;
        len_on_next    = len_on_reg;
        timer_next     = timer_reg;
        len_cnt_next   = len_cnt_reg;
        env_cd_next    = env_cd_reg;
        env_per_next   = env_per_reg;
        env_up_next    = env_up_reg;
        env_start_next = env_start_reg;
        vol_next       = vol_reg;
        shift_next     = shift_reg;
        short_next     = short_reg;
        div_next       = div_reg;
        lfsr_next      = lfsr_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_smp_next   = out_smp_reg;
        out_on_next    = out_on_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rd_next    = 8'h00;
                state_next = S_DONE;
                case (op_reg)
                    OP_WRITE:
                    begin
                        case (idx_reg)
                            REG_LENGTH:
                            begin
                                len_cnt_next = 7'd64 - {1'b0, data_reg[5:0]};
                            end
                            REG_VOLUME:
                            begin
                                vol_copy_next  = data_reg;
                                env_start_next = data_reg[7:4];
                                env_up_next    = data_reg[3];
                                env_per_next   = data_reg[2:0];
                                dac_next       = (data_reg[7:3] != 5'd0);
                                if (data_reg[7:3] == 5'd0)
                                begin
                                    en_next = 1'b0;
                                end
                            end
                            REG_POLY:
                            begin
                                shift_next = data_reg[7:4];
                                short_next = data_reg[3];
                                div_next   = data_reg[2:0];
                            end
                            REG_CONTROL:
                            begin
                                ctl_copy_next = data_reg;
                                len_on_next   = data_reg[6];
                                if (data_reg[7])
                                begin
                                    en_next = dac_reg;
                                    if (len_cnt_reg == 7'd0)
                                    begin
                                        len_cnt_next = 7'd64;
                                    end
                                    vol_next    = env_start_reg;
                                    env_cd_next = (env_per_reg == 3'd0) ? 4'd8
                                                                        : {1'b0, env_per_reg};
                                    lfsr_next   = LfsrSeed;
                                    acc_next    = {{(TimerWidth-7){1'b0}}, base_period(div_reg)};
                                    cnt_next    = shift_reg;
                                    state_next  = S_SHIFT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    OP_READ:
                    begin
                        case (idx_reg)
                            REG_VOLUME:  rd_next = vol_copy_reg;
                            REG_CONTROL: rd_next = ctl_copy_reg | 8'hBF;
                            default:     rd_next = 8'hFF;
                        endcase
                    end
                    OP_ADVANCE:
                    begin
                        if (en_reg)
                        begin
                            // Expire at or below zero: step once and rebuild the reload
                            if (alu_sum[TimerWidth-1] || alu_sum == '0)
                            begin
                                lfsr_next  = lfsr_step(lfsr_reg, short_reg);
                                acc_next   = {{(TimerWidth-7){1'b0}}, base_period(div_reg)};
                                cnt_next   = shift_reg;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                timer_next = alu_sum;
                            end
                        end
                    end
                    OP_LENGTH:
                    begin
                        if (len_on_reg)
                        begin
                            len_cnt_next = len_dec;
                            if (len_dec == 7'd0)
                            begin
                                en_next = 1'b0;
                            end
                        end
                    end
                    OP_ENV:
                    begin
                        if (env_per_reg != 3'd0)
                        begin
                            env_cd_next = env_cd_dec;
                            if (env_cd_dec == 4'd0)
                            begin
                                env_cd_next = {1'b0, env_per_reg};
                                if (env_up_reg)
                                begin
                                    if (vol_reg != 4'd15)
                                    begin
                                        vol_next = vol_reg + 4'd1;
                                    end
                                end
                                else if (vol_reg != 4'd0)
                                begin
                                    vol_next = vol_reg - 4'd1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (cnt_reg == 4'd0)
                begin
                    timer_next = acc_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next = alu_sum;
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_smp_next   = (en_reg && dac_reg && !lfsr_reg[0]) ? vol_reg : 4'd0;
                    out_on_next    = en_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vol_copy_reg  <= 8'h00;
            ctl_copy_reg  <= 8'h00;
            en_reg        <= 1'b0;
            dac_reg       <= 1'b0;
            len_on_reg    <= 1'b0;
            timer_reg     <= '0;
            len_cnt_reg   <= 7'd0;
            env_cd_reg    <= 4'd0;
            env_per_reg   <= 3'd0;
            env_up_reg    <= 1'b0;
            env_start_reg <= 4'd0;
            vol_reg       <= 4'd0;
            shift_reg     <= 4'd0;
            short_reg     <= 1'b0;
            div_reg       <= 3'd0;
            lfsr_reg      <= LfsrSeed;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vol_copy_reg  <= vol_copy_next;
            ctl_copy_reg  <= ctl_copy_next;
            en_reg        <= en_next;
            dac_reg       <= dac_next;
            len_on_reg    <= len_on_next;
            timer_reg     <= timer_next;
            len_cnt_reg   <= len_cnt_next;
            env_cd_reg    <= env_cd_next;
            env_per_reg   <= env_per_next;
            env_up_reg    <= env_up_next;
            env_start_reg <= env_start_next;
            vol_reg       <= vol_next;
            shift_reg     <= shift_next;
            short_reg     <= short_next;
            div_reg       <= div_next;
            lfsr_reg      <= lfsr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            idx_reg  <= req.reg_index;
            data_reg <= req.write_data;
            cyc_reg  <= req.cycles;
        end
        acc_reg    <= acc_next;
        rd_reg     <= rd_next;
        out_rd_reg <= out_rd_next;
        out_smp_reg <= out_smp_next;
        out_on_reg <= out_on_next;
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted item did not enter execution");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_enable_needs_dac: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(en_reg) |-> dac_reg)
        else $error("channel enabled with DAC off");

    a_reload_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && cnt_reg == 4'd0)
        |=> (!timer_reg[TimerWidth-1] && timer_reg != '0))
        else $error("timer reload not positive");

endmodule
